### design/fixed_partition_best_fit_allocator_assert.svh
// Assertion macros for the partition allocator.
`ifndef FIXED_PARTITION_BEST_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_BEST_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FPBF_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPBF_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

### design/fpbf_pkg.sv
package fpbf_pkg;

    localparam int PARTS_DEF     = 6;
    localparam int NUM_SIZE_REGS = 6;
    localparam int SIZE_W        = 8;
    localparam int CNT_W         = 11;
    localparam int ID_W          = 16;
    localparam int IDX_W         = 3;
    localparam int STAT_W        = 2;
    localparam int CFG_AW        = 3;
    localparam int CFG_DW        = 11;
    localparam int IN_W          = 24;
    localparam int OUT_BITS      = STAT_W + IDX_W + 3 * CNT_W;
    localparam int OUT_W         = 40;

    localparam logic [CNT_W-1:0] CNT_MAX     = '1;
    localparam logic [CNT_W-1:0] TOTAL_RESET = 11'd100;

    localparam logic [SIZE_W-1:0] SIZE_RESET [NUM_SIZE_REGS] =
        '{8'd40, 8'd25, 8'd15, 8'd10, 8'd8, 8'd2};

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_TOTAL = 3'd6;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] size;
    } t_scan_res;

    typedef struct packed {
        logic              apply;
        logic              op;
        logic [SIZE_W-1:0] req;
        logic [SIZE_W-1:0] size;
    } t_acct_cmd;

endpackage

### design/fpbf_scan.sv
// Walks the partitions one per cycle through a single compare unit.
module fpbf_scan import fpbf_pkg::*; #(
    parameter int PARTITIONS = PARTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  logic [ID_W-1:0]   i_pid,
    input  logic [SIZE_W-1:0] i_req,
    input  logic              i_busy,
    input  logic [ID_W-1:0]   i_owner,
    input  logic [SIZE_W-1:0] i_size,
    output logic [IDX_W-1:0]  o_idx,
    output logic              o_active,
    output logic              o_done,
    output t_scan_res         o_res
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(PARTITIONS - 1);

    logic              r_active;
    logic [IDX_W-1:0]  r_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [SIZE_W-1:0] r_best_slack;
    logic [SIZE_W-1:0] r_best_size;

    logic [SIZE_W-1:0] w_slack;
    logic              w_take;

    always_comb begin
        w_slack = i_size - i_req;
        if (i_op == OP_ALLOC) begin
            // ties go to the later index, hence <=
            w_take = !i_busy && (i_size >= i_req) && (!r_found || w_slack <= r_best_slack);
        end else begin
            // lowest owning index wins
            w_take = i_busy && (i_owner == i_pid) && !r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_found  <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_found  <= 1'b0;
        end else if (r_active) begin
            if (w_take) begin
                r_found <= 1'b1;
            end
            if (r_idx == LAST) begin
                r_active <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active && w_take) begin
            r_best_idx   <= r_idx;
            r_best_slack <= w_slack;
            r_best_size  <= i_size;
        end
    end

    assign o_idx        = r_idx;
    assign o_active     = r_active;
    assign o_done       = r_active && (r_idx == LAST);
    assign o_res.found  = r_found;
    assign o_res.idx    = r_found ? r_best_idx : '0;
    assign o_res.size   = r_best_size;

endmodule

### design/fpbf_acct.sv
// Memory accounting: used, total free and usable free, all saturating.
module fpbf_acct import fpbf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_reload,
    input  logic [CNT_W-1:0] i_total,
    input  t_acct_cmd        i_cmd,
    output logic [CNT_W-1:0] o_used,
    output logic [CNT_W-1:0] o_free,
    output logic [CNT_W-1:0] o_usable
);

    logic [CNT_W-1:0] r_used, r_free, r_usable;
    logic [CNT_W-1:0] n_used, n_free, n_usable;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [SIZE_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W + 1 - SIZE_W){1'b0}}, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(logic [CNT_W-1:0] a, logic [SIZE_W-1:0] b);
        logic [CNT_W-1:0] bx;
        bx = {{(CNT_W - SIZE_W){1'b0}}, b};
        return (a > bx) ? a - bx : '0;
    endfunction

    always_comb begin
        n_used   = r_used;
        n_free   = r_free;
        n_usable = r_usable;
        if (i_cmd.apply) begin
            if (i_cmd.op == OP_ALLOC) begin
                n_used   = sat_add(r_used, i_cmd.req);
                n_free   = sat_sub(r_free, i_cmd.req);
                n_usable = sat_sub(r_usable, i_cmd.size);
            end else begin
                n_used   = sat_sub(r_used, i_cmd.req);
                n_free   = sat_add(r_free, i_cmd.req);
                n_usable = sat_add(r_usable, i_cmd.size);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_free   <= TOTAL_RESET;
            r_usable <= TOTAL_RESET;
        end else if (i_reload) begin
            r_used   <= '0;
            r_free   <= i_total;
            r_usable <= i_total;
        end else begin
            r_used   <= n_used;
            r_free   <= n_free;
            r_usable <= n_usable;
        end
    end

    assign o_used   = r_used;
    assign o_free   = r_free;
    assign o_usable = r_usable;

endmodule

### design/fixed_partition_best_fit_allocator.sv
// Best-fit allocator over a set of fixed, size-programmable memory partitions.
// Input stream: one request per transaction; tuser carries the opcode (allocate
// or free), tdata the process id and request size. Output stream: one result per
// request with status, partition index and the three memory counters.
// Config port: write sizes (index 0..5) or total memory (index 6) while idle;
// a total memory write frees every partition and reloads the counters.
// Timing: after acceptance the scanner visits one partition per cycle through a
// single compare unit, then the update state writes the result register. A new
// request is taken only once the block is back in idle, so it does not accept a
// request while an earlier one is still being scanned or updated.
// Reset: all partitions free, used count zero, free counters at 100, sizes at
// their defaults. If the receiver stalls, the result holds and the block takes
// one more request, then waits in its update cycle until the result is taken.
module fixed_partition_best_fit_allocator import fpbf_pkg::*; #(
    parameter int PARTITIONS = PARTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,   // process_id[15:0], request_size[23:16]
    input  logic              i_s_tuser,   // opcode[0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // status[1:0], partition_index[4:2],
                                           // mem_used[15:5], total_free[26:16],
                                           // usable_free[37:27], zero pad above
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]  r_state, n_state;

    logic [SIZE_W-1:0] r_size [NUM_SIZE_REGS];
    logic [PARTITIONS-1:0] r_busy;
    logic [ID_W-1:0]   r_owner [PARTITIONS];

    logic              r_op;
    logic [ID_W-1:0]   r_pid;
    logic [SIZE_W-1:0] r_req;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_stat;
    logic [IDX_W-1:0]  r_out_idx;

    logic              w_accept;
    logic              w_reload;
    logic              w_commit;
    logic [IDX_W-1:0]  w_scan_idx;
    logic              w_scan_active;
    logic              w_scan_done;
    t_scan_res         w_res;
    t_acct_cmd         w_cmd;
    logic [CNT_W-1:0]  w_used, w_free, w_usable;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_reload = i_cfg_we && (i_cfg_addr == CFG_TOTAL);
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || i_m_tready);
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_SCAN;
            S_SCAN: if (w_scan_done) n_state = S_UPD;
            S_UPD:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tuser;
            r_pid <= i_s_tdata[ID_W-1:0];
            r_req <= i_s_tdata[ID_W +: SIZE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SIZE_REGS; i++) begin
                r_size[i] <= SIZE_RESET[i];
            end
        end else if (i_cfg_we && (i_cfg_addr < CFG_AW'(NUM_SIZE_REGS))) begin
            r_size[i_cfg_addr] <= i_cfg_wdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_reload) begin
            r_busy <= '0;
        end else if (w_commit && w_res.found) begin
            r_busy[w_res.idx[PW-1:0]] <= (r_op == OP_ALLOC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && w_res.found && (r_op == OP_ALLOC)) begin
            r_owner[w_res.idx[PW-1:0]] <= r_pid;
        end
    end

    fpbf_scan #(
        .PARTITIONS(PARTITIONS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_op     (r_op),
        .i_pid    (r_pid),
        .i_req    (r_req),
        .i_busy   (r_busy[w_scan_idx[PW-1:0]]),
        .i_owner  (r_owner[w_scan_idx[PW-1:0]]),
        .i_size   (r_size[w_scan_idx]),
        .o_idx    (w_scan_idx),
        .o_active (w_scan_active),
        .o_done   (w_scan_done),
        .o_res    (w_res)
    );

    assign w_cmd.apply = w_commit && w_res.found;
    assign w_cmd.op    = r_op;
    assign w_cmd.req   = r_req;
    assign w_cmd.size  = w_res.size;

    fpbf_acct u_acct (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_reload (w_reload),
        .i_total  (i_cfg_wdata[CNT_W-1:0]),
        .i_cmd    (w_cmd),
        .o_used   (w_used),
        .o_free   (w_free),
        .o_usable (w_usable)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_idx <= w_res.idx;
            if (w_res.found) begin
                r_out_stat <= ST_OK;
            end else if (r_op == OP_ALLOC) begin
                r_out_stat <= ST_NOFIT;
            end else begin
                r_out_stat <= ST_NOTFOUND;
            end
        end
    end

    // counters change only at commit or on a total memory write, so otherwise they stay matched to the held result
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, w_usable, w_free, w_used,
                         r_out_idx, r_out_stat};

`include "fixed_partition_best_fit_allocator_assert.svh"

    `FPBF_ASSERT_NXT(a_scan_starts, w_accept, w_scan_active, "scan did not start after accept")
    `FPBF_ASSERT_NOW(a_fail_idx_zero, o_m_tvalid && (r_out_stat != ST_OK), r_out_idx == '0, "failed result with nonzero index")
    `FPBF_ASSERT_NXT(a_busy_step, !w_reload, $countones(r_busy) <= $countones($past(r_busy)) + 1, "more than one partition taken at once")
    `FPBF_ASSERT_NOW(a_out_from_upd, $rose(o_m_tvalid), $past(r_state) == S_UPD, "result raised outside update")

endmodule
